// ----- rtl/bounded_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// bounded list engine assertion macros
// assertion wrappers that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BLE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/ble_pkg.sv -----
// ----------------------------------------------------------------------------
// ble_pkg
// operation and status codes for the bounded list engine
// ----------------------------------------------------------------------------
package ble_pkg;

  typedef enum logic [3:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_REMOVE  = 4'd2,
    OP_POP     = 4'd3,
    OP_GET     = 4'd4,
    OP_SET     = 4'd5,
    OP_CLEAR   = 4'd6,
    OP_INDEX   = 4'd7,
    OP_COUNT   = 4'd8,
    OP_REVERSE = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 10;
  localparam int unsigned OUT_W = 9;

endpackage

// ----- rtl/ble_mem.sv -----
// ----------------------------------------------------------------------------
// ble_mem
// element store: one write port and one registered read port
// ----------------------------------------------------------------------------
module ble_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ble_pkg::VAL_W-1:0]   wdata,
  input  logic [AW-1:0]               raddr,
  output logic [ble_pkg::VAL_W-1:0]   rdata
);

  logic [ble_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bounded_list_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_list_engine
// ordered list of signed 64-bit values in a fixed store
// ----------------------------------------------------------------------------
// One item is taken at a time through a single-port-write, single-port-read
// memory walked by a small sequencer. Append, set, clear and the unused
// selectors finish from the dispatch state; get and pop read one entry; insert
// moves entries one at a time from the tail up toward the position; remove
// moves entries one at a time down from the position; index_of and count read
// every entry; reverse swaps entries pair by pair from both ends. The slowest
// operation is an insert or remove at the head of a nearly full list. The
// result sits in an output register and in_ready returns the cycle after it is
// taken. The store needs no clearing after reset.
`include "bounded_list_engine_defines.svh"

module bounded_list_engine #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        func,
  input  logic signed [ble_pkg::POS_W-1:0]  position,
  input  logic signed [ble_pkg::VAL_W-1:0]  operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ble_pkg::VAL_W-1:0]  read_value,
  output logic signed [ble_pkg::OUT_W-1:0]  found_position,
  output logic [ble_pkg::OUT_W-1:0]         match_count,
  output logic [ble_pkg::OUT_W-1:0]         list_length,
  output logic [1:0]                        status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > ble_pkg::POS_W) ? CW + 1 : ble_pkg::POS_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_WAIT, S_RD_DONE, S_MOVE_RD, S_MOVE_WR,
    S_SCAN, S_SCAN_LAST, S_REV_RDB, S_REV_WRA, S_REV_WRB, S_DONE
  } state_t;

  state_t state;
  logic [3:0] op;
  logic signed [XW-1:0] pos;
  logic [ble_pkg::VAL_W-1:0] val;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] hi;
  logic [ble_pkg::VAL_W-1:0] hold;
  logic found_flag;

  logic we;
  logic [AW-1:0] waddr;
  logic [ble_pkg::VAL_W-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [ble_pkg::VAL_W-1:0] rdata;

  logic signed [XW-1:0] cnt_s;
  logic signed [XW-1:0] gpos;
  logic [XW-1:0] upos;

  assign cnt_s = XW'(signed'({1'b0, count}));
  assign gpos  = (pos < 0) ? pos + cnt_s : pos;
  assign upos  = XW'(gpos);

  ble_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = val;
    raddr = idx[AW-1:0];
    case (state)
      S_DISPATCH: begin
        case (op)
          ble_pkg::OP_APPEND: begin
            we    = (count < CW'(DEPTH));
            waddr = count[AW-1:0];
          end
          ble_pkg::OP_SET: begin
            we    = (gpos >= 0) && (gpos < cnt_s);
            waddr = upos[AW-1:0];
          end
          ble_pkg::OP_POP: raddr = AW'(count - CW'(1));
          ble_pkg::OP_GET, ble_pkg::OP_REMOVE: raddr = upos[AW-1:0];
          ble_pkg::OP_INSERT: raddr = AW'(count - CW'(1));
          ble_pkg::OP_REVERSE: raddr = idx[AW-1:0];
          default: raddr = idx[AW-1:0];
        endcase
      end
      S_MOVE_RD: raddr = idx[AW-1:0];
      S_MOVE_WR: begin
        we    = 1'b1;
        wdata = rdata;
        waddr = (op == ble_pkg::OP_INSERT) ? AW'(idx + CW'(1)) : AW'(idx - CW'(1));
      end
      S_SCAN: raddr = AW'(idx + CW'(1));
      S_REV_RDB: begin
        raddr = hi[AW-1:0];
      end
      S_REV_WRA: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      S_REV_WRB: begin
        we    = 1'b1;
        waddr = hi[AW-1:0];
        wdata = hold;
        raddr = AW'(idx + CW'(1));
      end
      S_RD_DONE: begin
        we    = (op == ble_pkg::OP_INSERT);
        waddr = upos[AW-1:0];
        wdata = val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= func;
            pos   <= XW'(position);
            val   <= operand_value;
            idx   <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          read_value     <= '0;
          found_position <= '0;
          match_count    <= '0;
          status         <= ble_pkg::ST_OK;
          state          <= S_DONE;
          case (op)
            ble_pkg::OP_APPEND: begin
              if (count < CW'(DEPTH)) count <= count + CW'(1);
              else status <= ble_pkg::ST_FULL;
            end
            ble_pkg::OP_INSERT: begin
              if (pos < 0 || pos > cnt_s) status <= ble_pkg::ST_RANGE;
              else if (count >= CW'(DEPTH)) status <= ble_pkg::ST_FULL;
              else if (upos[CW-1:0] == count) state <= S_RD_DONE;
              else begin
                idx   <= count - CW'(1);
                state <= S_MOVE_WR;
              end
            end
            ble_pkg::OP_REMOVE: begin
              if (pos < 0 || pos >= cnt_s) status <= ble_pkg::ST_RANGE;
              else begin
                idx   <= upos[CW-1:0];
                state <= S_RD_WAIT;
              end
            end
            ble_pkg::OP_POP: begin
              if (count == '0) status <= ble_pkg::ST_EMPTY;
              else begin
                count <= count - CW'(1);
                state <= S_RD_WAIT;
              end
            end
            ble_pkg::OP_GET: begin
              if (gpos < 0 || gpos >= cnt_s) status <= ble_pkg::ST_RANGE;
              else state <= S_RD_WAIT;
            end
            ble_pkg::OP_SET: begin
              if (gpos < 0 || gpos >= cnt_s) status <= ble_pkg::ST_RANGE;
            end
            ble_pkg::OP_CLEAR: count <= '0;
            ble_pkg::OP_INDEX, ble_pkg::OP_COUNT: begin
              if (op == ble_pkg::OP_INDEX) found_position <= '1;
              found_flag <= 1'b0;
              if (count != '0) state <= (count == CW'(1)) ? S_SCAN_LAST : S_SCAN;
            end
            ble_pkg::OP_REVERSE: begin
              hi <= count - CW'(1);
              if (count > CW'(1)) state <= S_REV_RDB;
            end
            default: ;
          endcase
        end
        S_RD_WAIT: begin
          read_value <= rdata;
          if (op == ble_pkg::OP_REMOVE && idx + CW'(1) < count) begin
            idx   <= idx + CW'(1);
            state <= S_MOVE_RD;
          end else begin
            if (op == ble_pkg::OP_REMOVE) count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          if (op == ble_pkg::OP_INSERT) begin
            if (idx == upos[CW-1:0]) state <= S_RD_DONE;
            else begin
              idx   <= idx - CW'(1);
              state <= S_MOVE_RD;
            end
          end else begin
            if (idx + CW'(1) < count) begin
              idx   <= idx + CW'(1);
              state <= S_MOVE_RD;
            end else begin
              count <= count - CW'(1);
              state <= S_DONE;
            end
          end
        end
        S_RD_DONE: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_SCAN, S_SCAN_LAST: begin
          if (rdata == val) begin
            match_count <= match_count + ble_pkg::OUT_W'(1);
            if (!found_flag) found_position <= ble_pkg::OUT_W'(idx);
            found_flag <= 1'b1;
          end
          idx <= idx + CW'(1);
          if (state == S_SCAN_LAST) begin
            if (op == ble_pkg::OP_INDEX) match_count <= '0;
            else found_position <= '0;
            state <= S_DONE;
          end else if (idx + CW'(2) >= count) state <= S_SCAN_LAST;
        end
        S_REV_RDB: begin
          hold  <= rdata;
          state <= S_REV_WRA;
        end
        S_REV_WRA: state <= S_REV_WRB;
        S_REV_WRB: begin
          idx <= idx + CW'(1);
          hi  <= hi - CW'(1);
          if (idx + CW'(1) < hi - CW'(1)) state <= S_REV_RDB;
          else state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            list_length <= ble_pkg::OUT_W'(count);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BLE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `BLE_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid)
  `BLE_ASSERT_NEXT(a_out_drop, clk, rst, out_valid && out_ready, in_ready)

endmodule
